// ===== sv/bandlimited_waveform_oscillator_top_macros.svh =====
// assertion macros for the oscillator checker
// no dependencies
`ifndef BANDLIMITED_WAVEFORM_OSCILLATOR_TOP_MACROS_SVH
`define BANDLIMITED_WAVEFORM_OSCILLATOR_TOP_MACROS_SVH

// plain clocked property, off while reset is low
`define BWO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("oscillator check failed");

// a stalled beat keeps its valid and its payload
`define BWO_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, dat) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(dat))) \
    else $error("stalled beat changed");

`endif

// ===== sv/bwo_pkg.sv =====
// shared types, constants and the sine polynomial for the oscillator
// no dependencies
`default_nettype none
package bwo_pkg;

  localparam int    QF     = 30;
  localparam int    ACC_W  = 36;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint Q_ONE  = 64'sd1 <<< QF;
  // 1/3 as a 32 bit reciprocal scaled by 2^33, exact for 32 bit dividends
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  typedef enum logic [2:0] {
    WF_SINE      = 3'd0,
    WF_SAW       = 3'd1,
    WF_SQUARE    = 3'd2,
    WF_TRIANGLE  = 3'd3,
    WF_COSINE    = 3'd4,
    WF_RAMP      = 3'd5,
    WF_RECTANGLE = 3'd6
  } wave_e;

  typedef enum logic [1:0] {
    REG_WAVEFORM    = 2'd0,
    REG_INCREMENT   = 2'd1,
    REG_PULSE_WIDTH = 2'd2
  } cfg_reg_e;

  // q30 product, truncated toward zero on the magnitude
  function automatic longint mulq(input longint a, input longint b);
    logic        neg;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] m;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? 64'(-a) : 64'(a);
    mb  = (b < 0) ? 64'(-b) : 64'(b);
    m   = (ma * mb) >> QF;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // sin(x) on the first quadrant, horner form taylor series
  function automatic longint sine_poly(input longint x);
    longint x2;
    longint h;
    x2 = mulq(x, x);
    h  = Q_ONE;
    h  = Q_ONE - mulq(x2, h) / 156;
    h  = Q_ONE - mulq(x2, h) / 110;
    h  = Q_ONE - mulq(x2, h) / 72;
    h  = Q_ONE - mulq(x2, h) / 42;
    h  = Q_ONE - mulq(x2, h) / 20;
    h  = Q_ONE - mulq(x2, h) / 6;
    return mulq(x, h);
  endfunction

endpackage
`default_nettype wire

// ===== sv/bwo_if.sv =====
// handshake channels of the oscillator: tick in, sample out, register writes
// no dependencies
`default_nettype none
interface bwo_tick_if #(parameter int PB = 24);
  logic          valid;
  logic          ready;
  logic          sync_request;
  logic [PB-1:0] sync_phase;
  modport source (output valid, output sync_request, output sync_phase, input ready);
  modport sink   (input valid, input sync_request, input sync_phase, output ready);
endinterface

interface bwo_sample_if #(parameter int SB = 24);
  logic                 valid;
  logic                 ready;
  logic signed [SB-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bwo_cfg_if #(parameter int PB = 24);
  logic          valid;
  logic          ready;
  logic [1:0]    index;
  logic [PB-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/bwo_div.sv =====
// restoring divider, (num << 30) / den for num < den, one quotient bit a cycle
// depends on bwo_pkg
`default_nettype none
module bwo_div
  import bwo_pkg::*;
#(
  parameter int W = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  output logic          done_o,
  output logic [QF-1:0] quot_o
);

  logic          busy_q, done_q;
  logic [4:0]    cnt_q;
  logic [W-1:0]  rem_q, den_q;
  logic [QF-1:0] quot_q;
  logic [W:0]    shifted;
  logic          ge;

  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QF);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? W'(shifted - {1'b0, den_q}) : W'(shifted);
      quot_q <= {quot_q[QF-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ===== sv/bwo_mul.sv =====
// shared 32 x 32 unsigned multiplier with registered product
// no dependencies
`default_nettype none
module bwo_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== sv/bwo_sine_rom.sv =====
// quarter wave sine table, q30, two registered read ports
// depends on bwo_pkg (sine polynomial)
`default_nettype none
module bwo_sine_rom
  import bwo_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 9
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [AW-1:0]       addr_lo_i,
  input  logic [AW-1:0]       addr_hi_i,
  output logic signed [31:0]  lo_o,
  output logic signed [31:0]  hi_o
);

  typedef logic signed [31:0] rom_t [DEPTH+2];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= DEPTH; i++) begin
      r[i] = 32'(sine_poly(PI_Q30 * longint'(i) / (2 * DEPTH)));
    end
    r[DEPTH+1] = r[DEPTH];
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic signed [31:0] lo_q, hi_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= ROM[addr_lo_i];
      hi_q <= ROM[addr_hi_i];
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule
`default_nettype wire

// ===== sv/bandlimited_waveform_oscillator_top.sv =====
// sine, cosine and high frequency: a tick beat runs setup, table position, table read,
// interpolation multiply and accumulate, then done raises sample valid; a triangle with
// both corners corrected runs per correction a check, a divide and up to four passes
// through the shared multiplier. a new tick beat waits for idle; sink stalls delay it
// reset: phase 0, waveform sine, increment 0, pulse width one half, no sample pending
// depends on bwo_pkg, bwo_if, bwo_div, bwo_mul, bwo_sine_rom
`default_nettype none
module bandlimited_waveform_oscillator_top
  import bwo_pkg::*;
#(
  parameter int PHASE_BITS       = 24,
  parameter int SAMPLE_BITS      = 24,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bwo_cfg_if.sink       cfg_i,
  bwo_tick_if.sink      tick_i,
  bwo_sample_if.source  sample_o
);

  localparam int PB = PHASE_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(SINE_TABLE_DEPTH + 2);
  // fraction bits dropped when rounding q30 to the sample format
  localparam int SH = QF - (SB - 3);

  localparam logic [PB-1:0] HALF    = PB'(1) << (PB - 1);
  localparam logic [PB-1:0] QUARTER = PB'(1) << (PB - 2);

  localparam logic signed [ACC_W-1:0] ONE    = ACC_W'(1) <<< QF;
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (SH - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SB - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (SB - 1));

  // sequencer, one-hot
  typedef enum logic [13:0] {
    S_IDLE    = 14'b00_0000_0000_0001,
    S_SETUP   = 14'b00_0000_0000_0010,
    S_SIN_POS = 14'b00_0000_0000_0100,
    S_SIN_RD  = 14'b00_0000_0000_1000,
    S_SIN_MUL = 14'b00_0000_0001_0000,
    S_SIN_ACC = 14'b00_0000_0010_0000,
    S_CHK     = 14'b00_0000_0100_0000,
    S_DIV     = 14'b00_0000_1000_0000,
    S_SQ      = 14'b00_0001_0000_0000,
    S_CUBE    = 14'b00_0010_0000_0000,
    S_THIRD   = 14'b00_0100_0000_0000,
    S_SCALE   = 14'b00_1000_0000_0000,
    S_CORR    = 14'b01_0000_0000_0000,
    S_DONE    = 14'b10_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // registers written over the config port, and the phase accumulator
  logic [2:0]    waveform_q;
  logic [PB-1:0] dt_q, pw_q;
  logic [PB-1:0] phase_q;

  // per sample working set
  logic [PB-1:0]             t_q, sarg_q, arg0_q, arg1_q;
  logic                      sgn0_q, sgn1_q, en1_q, blamp_q, slot_q, side_q, neg_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [QF:0]               r_q;
  logic [27:0]               frac_q;
  logic                      out_valid_q;
  logic signed [SB-1:0]      out_q;

  logic tick_acc;
  assign tick_acc = tick_i.valid && tick_i.ready;

  function automatic logic [QF-1:0] to_q30(input logic [PB-1:0] p);
    logic [PB+QF-1:0] w;
    w = {p, QF'(0)} >> PB;
    return w[QF-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] ext(input logic [QF-1:0] q);
    return signed'(ACC_W'(q));
  endfunction

  // shared units
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic          div_start, div_done;
  logic [PB-1:0] div_num;
  logic [QF-1:0] div_quot;
  logic signed [31:0] rom_lo, rom_hi;

  // sine addressing
  logic [QF-1:0] sq30;
  logic [28:0]   sin_f;
  logic [35:0]   idx_full;

  bwo_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  bwo_div #(.W(PB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // table index comes straight from the position product
  bwo_sine_rom #(.DEPTH(SINE_TABLE_DEPTH), .AW(AW)) u_rom (
    .clk_i     (clk_i),
    .en_i      (state_q == S_SIN_RD),
    .addr_lo_i (AW'(idx_full)),
    .addr_hi_i (AW'(idx_full + 36'd1)),
    .lo_o      (rom_lo),
    .hi_o      (rom_hi)
  );

  // waveform set-up: base value and the arguments of the two corrections
  logic [PB-1:0] t_half, t_qtr, t_3q, t_pw;
  logic signed [ACC_W-1:0] q_t, q_h, q_pw, y4, tri_y;
  logic                    use_sine, hf;
  logic signed [ACC_W-1:0] base;
  logic [PB-1:0]           su_arg0, su_arg1, su_sarg;
  logic                    su_sgn0, su_sgn1, su_en1, su_blamp;

  always_comb begin
    t_half = t_q + HALF;
    t_qtr  = t_q + QUARTER;
    t_3q   = t_q + HALF + QUARTER;
    t_pw   = t_q - pw_q;
    q_t    = ext(to_q30(t_q));
    q_h    = ext(to_q30(t_half));
    q_pw   = ext(to_q30(pw_q));
    y4     = q_t <<< 2;
    if (y4 >= 3 * ONE) begin
      tri_y = y4 - 4 * ONE;
    end else if (y4 > ONE) begin
      tri_y = 2 * ONE - y4;
    end else begin
      tri_y = y4;
    end
    hf       = dt_q >= QUARTER;
    use_sine = 1'b0;
    base     = '0;
    su_arg0  = t_q;
    su_arg1  = t_q;
    su_sgn0  = 1'b0;
    su_sgn1  = 1'b1;
    su_en1   = 1'b0;
    su_blamp = 1'b0;
    su_sarg  = t_q;
    case (wave_e'(waveform_q))
      WF_SAW: begin
        base    = 2 * q_h - ONE;
        su_arg0 = t_half;
        su_sgn0 = 1'b1;
      end
      WF_SQUARE: begin
        base    = (t_q < HALF) ? ONE : -ONE;
        su_arg1 = t_half;
        su_en1  = 1'b1;
      end
      WF_TRIANGLE: begin
        base     = tri_y;
        su_arg0  = t_qtr;
        su_arg1  = t_3q;
        su_en1   = 1'b1;
        su_blamp = 1'b1;
      end
      WF_COSINE: begin
        use_sine = 1'b1;
        su_sarg  = t_qtr;
      end
      WF_RAMP: begin
        base    = ONE - 2 * q_h;
        su_arg0 = t_half;
      end
      WF_RECTANGLE: begin
        base    = -2 * q_pw + ((t_q < pw_q) ? 2 * ONE : '0);
        su_arg1 = t_pw;
        su_en1  = 1'b1;
      end
      default: begin
        use_sine = 1'b1;
      end
    endcase
    // high frequency falls back to plain sine
    if (hf) begin
      use_sine = 1'b1;
      su_sarg  = t_q;
    end
  end

  always_comb begin
    sq30     = to_q30(sarg_q);
    sin_f    = sq30[28] ? (29'(1) << 28) - {1'b0, sq30[27:0]} : {1'b0, sq30[27:0]};
    idx_full = prod[63:28];
    if (idx_full > 36'(SINE_TABLE_DEPTH)) begin
      idx_full = 36'(SINE_TABLE_DEPTH);
    end
  end

  // correction slot under work
  logic [PB-1:0] u;
  logic          u_low, u_high;
  logic          more;
  always_comb begin
    u      = slot_q ? arg1_q : arg0_q;
    u_low  = u < dt_q;
    u_high = {1'b0, u} > (((PB+1)'(1) << PB) - {1'b0, dt_q});
    more   = !slot_q && en1_q;
  end

  // correction magnitude and its sign; a full-scale square needs bit 30
  logic [63:0]             scaled;
  logic signed [ACC_W-1:0] corr;
  logic                    corr_neg;
  always_comb begin
    scaled   = prod >> PB;
    corr     = blamp_q ? signed'(scaled[ACC_W-1:0]) : signed'(ACC_W'(prod[QF+30:QF]));
    corr_neg = (slot_q ? sgn1_q : sgn0_q) ^ (!blamp_q && !side_q);
  end

  // rounding and saturation
  logic signed [ACC_W-1:0] rnd, res;
  always_comb begin
    rnd = (acc_q + RND) >>> SH;
    if (rnd > SAT_HI) begin
      res = SAT_HI;
    end else if (rnd < SAT_LO) begin
      res = SAT_LO;
    end else begin
      res = rnd;
    end
  end

  // sine interpolation sum
  logic signed [ACC_W-1:0] sin_v;
  logic [63:0]             interp;
  assign interp = prod >> 28;
  assign sin_v  = ACC_W'(rom_lo) + signed'(interp[ACC_W-1:0]);

  // next state and shared unit operands
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = u_low ? u : PB'(0) - u;
    unique case (state_q)
      S_IDLE: begin
        if (tick_acc) state_d = S_SETUP;
      end
      S_SETUP: begin
        state_d = use_sine ? S_SIN_POS : S_CHK;
      end
      S_SIN_POS: begin
        mul_a   = 32'(sin_f);
        mul_b   = 32'(SINE_TABLE_DEPTH);
        state_d = S_SIN_RD;
      end
      S_SIN_RD: begin
        state_d = S_SIN_MUL;
      end
      S_SIN_MUL: begin
        mul_a   = unsigned'(rom_hi - rom_lo);
        mul_b   = 32'(frac_q);
        state_d = S_SIN_ACC;
      end
      S_SIN_ACC: begin
        state_d = S_DONE;
      end
      S_CHK: begin
        if (u_low || u_high) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else if (!more) begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_SQ;
      end
      S_SQ: begin
        mul_a   = 32'(r_q);
        mul_b   = 32'(r_q);
        state_d = blamp_q ? S_CUBE : S_CORR;
      end
      S_CUBE: begin
        mul_a   = prod[QF+31:QF];
        mul_b   = 32'(r_q);
        state_d = S_THIRD;
      end
      S_THIRD: begin
        mul_a   = prod[QF+31:QF];
        mul_b   = RECIP3;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        mul_a   = 32'(PB'({dt_q, 2'b00}));
        mul_b   = {1'b0, prod[63:33]};
        state_d = S_CORR;
      end
      S_CORR: begin
        state_d = more ? S_CHK : S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || sample_o.ready) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state, config registers and phase accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      waveform_q  <= 3'(WF_SINE);
      dt_q        <= '0;
      pw_q        <= HALF;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_reg_e'(cfg_i.index))
          REG_WAVEFORM:    waveform_q <= cfg_i.data[2:0];
          REG_INCREMENT:   dt_q       <= cfg_i.data;
          REG_PULSE_WIDTH: pw_q       <= cfg_i.data;
          default: ;
        endcase
      end
      if (tick_acc) begin
        phase_q <= (tick_i.sync_request ? tick_i.sync_phase : phase_q) + dt_q;
      end
      if (state_q == S_DONE && (!out_valid_q || sample_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (sample_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      t_q <= tick_i.sync_request ? tick_i.sync_phase : phase_q;
    end
    unique case (state_q)
      S_SETUP: begin
        acc_q   <= base;
        arg0_q  <= su_arg0;
        arg1_q  <= su_arg1;
        sgn0_q  <= su_sgn0;
        sgn1_q  <= su_sgn1;
        en1_q   <= su_en1;
        blamp_q <= su_blamp;
        sarg_q  <= su_sarg;
        slot_q  <= 1'b0;
      end
      S_SIN_POS: begin
        neg_q <= sq30[29];
      end
      S_SIN_RD: begin
        frac_q <= prod[27:0];
      end
      S_SIN_ACC: begin
        acc_q <= neg_q ? -sin_v : sin_v;
      end
      S_CHK: begin
        side_q <= !u_low;
        if (!(u_low || u_high) && more) slot_q <= 1'b1;
      end
      S_DIV: begin
        if (div_done) r_q <= ((QF+1)'(1) << QF) - {1'b0, div_quot};
      end
      S_CORR: begin
        acc_q <= corr_neg ? acc_q - corr : acc_q + corr;
        if (more) slot_q <= 1'b1;
      end
      S_DONE: begin
        if (!out_valid_q || sample_o.ready) out_q <= SB'(res);
      end
      default: ;
    endcase
  end

  assign tick_i.ready    = (state_q == S_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign sample_o.valid  = out_valid_q;
  assign sample_o.sample = out_q;

endmodule
`default_nettype wire

// ===== sv/bwo_checker.sv =====
// port level checks on the oscillator, bound to the top level
// depends on bandlimited_waveform_oscillator_top_macros.svh
`default_nettype none
`include "bandlimited_waveform_oscillator_top_macros.svh"
module bwo_checker #(
  parameter int SB = 24
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          tick_valid_i,
  input logic          tick_ready_i,
  input logic          sample_valid_i,
  input logic          sample_ready_i,
  input logic [SB-1:0] sample_i
);

  // a waiting sample beat holds
  `BWO_ASSERT_HOLD(a_sample_hold, clk_i, rst_ni, sample_valid_i, sample_ready_i, sample_i)
  // a tick beat starts work, so the next one waits
  `BWO_ASSERT(a_busy_after_tick, clk_i, rst_ni, (tick_valid_i && tick_ready_i) |=> !tick_ready_i)
  // a new sample only ever comes out of a busy sequencer
  `BWO_ASSERT(a_result_from_work, clk_i, rst_ni, $rose(sample_valid_i) |-> $past(!tick_ready_i))
  // no sample straight after a tick beat
  `BWO_ASSERT(a_no_instant_result, clk_i, rst_ni, (tick_valid_i && tick_ready_i) |=> !$rose(sample_valid_i))

endmodule

bind bandlimited_waveform_oscillator_top bwo_checker #(.SB(SAMPLE_BITS)) u_bwo_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .tick_valid_i   (tick_i.valid),
  .tick_ready_i   (tick_i.ready),
  .sample_valid_i (sample_o.valid),
  .sample_ready_i (sample_o.ready),
  .sample_i       (sample_o.sample)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking regression for the band-limited waveform oscillator
// depends on bwo_pkg, the channel interfaces in bwo_if and the oscillator top level
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import bwo_pkg::*;

  localparam int          CLK_PERIOD   = 20;
  localparam int          CYCLE_LIMIT  = 400000;
  // settle time before register writes, well above the worst sample latency
  localparam int          DRAIN_CYCLES = 120;
  localparam logic [2:0]  WF_UNUSED    = 3'd7;
  localparam logic [23:0] PH_QUARTER   = 24'h40_0000;
  localparam logic [23:0] PH_HALF      = 24'h80_0000;
  localparam longint      ONE_Q30      = 64'sd1 <<< 30;
  localparam longint      PI_FIXED     = 64'sd3373259426;

  logic clk_i;
  logic rst_ni;

  bwo_cfg_if    cfg ();
  bwo_tick_if   tick ();
  bwo_sample_if smp ();

  bandlimited_waveform_oscillator_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .tick_i   (tick),
    .sample_o (smp)
  );

  // shadow copy of the oscillator state, updated on accepted beats
  logic [2:0]  wave_sel;
  logic [23:0] step_inc;
  logic [23:0] duty;
  logic [23:0] acc_phase;
  longint      quarter_rom [0:257];

  logic [23:0] expected_samples [$];
  int          cycle_count;
  int          mismatches;
  int          ticks_sent;
  int          samples_seen;
  int          wave_hits [0:7];
  int          hold_request;   // one-off long stall for the sample sink
  bit          quiet_mode;     // no idling on either side

  // clock and watchdog
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bandlimited_waveform_oscillator_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // q30 product, magnitude truncated
  function automatic longint q_mul(input longint a, input longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    longint      m;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    m  = longint'((ma * mb) >> 30);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint to_q30(input logic [23:0] p);
    return longint'({40'd0, p}) <<< 6;
  endfunction

  // first-quadrant sine, nested taylor terms
  function automatic longint taylor_sine(input longint x);
    longint x2;
    longint h;
    longint dv [6];
    dv = '{156, 110, 72, 42, 20, 6};
    x2 = q_mul(x, x);
    h  = ONE_Q30;
    for (int i = 0; i < 6; i++) h = ONE_Q30 - q_mul(x2, h) / dv[i];
    return q_mul(x, h);
  endfunction

  // quarter-wave lookup with linear interpolation, mirrored per quadrant
  function automatic longint rom_sine(input logic [23:0] p);
    logic [63:0] q;
    logic [63:0] f;
    logic [63:0] pos;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [1:0]  quad;
    longint      v;
    q    = {40'd0, p} << 6;
    quad = q[29:28];
    f    = q & 64'h0FFF_FFFF;
    if (quad[0]) f = 64'h1000_0000 - f;
    pos  = f * 256;
    idx  = pos >> 28;
    frac = pos & 64'h0FFF_FFFF;
    if (idx > 256) idx = 256;
    v = quarter_rom[idx] +
        longint'((64'(quarter_rom[idx + 1] - quarter_rom[idx]) * frac) >> 28);
    return quad[1] ? -v : v;
  endfunction

  // distance into the correction window, as 1 - t/dt; -1 outside it
  function automatic longint edge_ratio(input logic [23:0] t, input logic [23:0] dt);
    logic [63:0] tw;
    logic [63:0] dw;
    tw = {40'd0, t};
    dw = {40'd0, dt};
    if (tw < dw) return ONE_Q30 - longint'((tw << 30) / dw);
    if (tw > 64'h100_0000 - dw) return ONE_Q30 - longint'(((64'h100_0000 - tw) << 30) / dw);
    return -1;
  endfunction

  function automatic longint step_fix(input logic [23:0] t, input logic [23:0] dt);
    longint r;
    r = edge_ratio(t, dt);
    if (r < 0) return 0;
    return ({40'd0, t} < {40'd0, dt}) ? -q_mul(r, r) : q_mul(r, r);
  endfunction

  function automatic longint corner_fix(input logic [23:0] t, input logic [23:0] dt);
    longint r;
    longint b;
    r = edge_ratio(t, dt);
    if (r < 0) return 0;
    b = q_mul(q_mul(r, r), r) / 3;
    return longint'((64'd4 * {40'd0, dt} * 64'(b)) >> 24);
  endfunction

  function automatic longint wave_value(input logic [23:0] t);
    logic [23:0] t2;
    longint      y;
    if (step_inc >= PH_QUARTER) return rom_sine(t);
    case (wave_sel)
      WF_SAW: begin
        t2 = t + PH_HALF;
        return 2 * to_q30(t2) - ONE_Q30 - step_fix(t2, step_inc);
      end
      WF_SQUARE: begin
        y = (t < PH_HALF) ? ONE_Q30 : -ONE_Q30;
        return y + step_fix(t, step_inc) - step_fix(t + PH_HALF, step_inc);
      end
      WF_TRIANGLE: begin
        y = 4 * to_q30(t);
        if (y >= 3 * ONE_Q30) y = y - 4 * ONE_Q30;
        else if (y > ONE_Q30) y = 2 * ONE_Q30 - y;
        return y + corner_fix(t + PH_QUARTER, step_inc)
                 - corner_fix(t + PH_HALF + PH_QUARTER, step_inc);
      end
      WF_COSINE: return rom_sine(t + PH_QUARTER);
      WF_RAMP: begin
        t2 = t + PH_HALF;
        return ONE_Q30 - 2 * to_q30(t2) + step_fix(t2, step_inc);
      end
      WF_RECTANGLE: begin
        y = -2 * to_q30(duty);
        if (t < duty) y = y + 2 * ONE_Q30;
        return y + step_fix(t, step_inc) - step_fix(t - duty, step_inc);
      end
      default: return rom_sine(t);
    endcase
  endfunction

  // q30 to q2.21 with round half up and saturation
  function automatic logic [23:0] to_sample(input longint v);
    longint r;
    r = (v + 256) >>> 9;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[23:0];
  endfunction

  // --------------------------------------------------------------- drivers

  task automatic write_reg(input cfg_reg_e idx, input logic [23:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      REG_WAVEFORM:    wave_sel = val[2:0];
      REG_INCREMENT:   step_inc = val;
      REG_PULSE_WIDTH: duty     = val;
      default: ;
    endcase
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // one tick beat; valid stays high afterwards so a gapless follower keeps it up
  task automatic send_tick(input logic req, input logic [23:0] ph);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      tick.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick.valid        <= 1'b1;
    tick.sync_request <= req;
    tick.sync_phase   <= ph;
    do @(posedge clk_i); while (!tick.ready);
    if (req) acc_phase = ph;
    expected_samples.push_back(to_sample(wave_value(acc_phase)));
    wave_hits[(step_inc >= PH_QUARTER) ? 0 : wave_sel]++;
    acc_phase = acc_phase + step_inc;
    ticks_sent++;
  endtask

  // wait until every sample is back, then let the pipeline go quiet
  task automatic drain();
    tick.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_voice(input logic [2:0] wf, input logic [23:0] inc,
                           input logic [23:0] pw);
    drain();
    write_reg(REG_WAVEFORM, {21'd0, wf});
    write_reg(REG_INCREMENT, inc);
    write_reg(REG_PULSE_WIDTH, pw);
  endtask

  // sample sink: random stalls, plus a long one on request
  initial begin
    int stall;
    smp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = quiet_mode ? 0 : $urandom_range(0, 9);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        smp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      smp.ready <= 1'b1;
      do @(posedge clk_i); while (!smp.valid);
      samples_seen++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %0d", $signed(smp.sample));
      end else begin
        logic [23:0] want;
        want = expected_samples.pop_front();
        if (smp.sample !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample %0d: expected %0d, got %0d", samples_seen,
                     $signed(want), $signed(smp.sample));
        end
      end
    end
  end

  // ------------------------------------------------------------------ tests

  // every waveform, the unused selector, extremes of increment, phase and duty
  task automatic test_directed();
    logic [2:0] wf;
    for (int w = 0; w <= int'(WF_UNUSED); w++) begin
      wf = w[2:0];
      set_voice(wf, 24'h01_0000, 24'h80_0000);
      send_tick(1'b1, 24'h00_0000);
      send_tick(1'b1, 24'hFF_FFFF);
    end
    // zero increment: no correction, no divide
    set_voice(WF_SAW, 24'h00_0000, 24'h80_0000);
    send_tick(1'b1, 24'h80_0000);
    // just below, at and above the high frequency limit
    set_voice(WF_SQUARE, PH_QUARTER - 1, 24'h80_0000);
    send_tick(1'b1, 24'h00_1234);
    set_voice(WF_TRIANGLE, PH_QUARTER, 24'h80_0000);
    send_tick(1'b0, 24'h00_0000);
    set_voice(WF_RAMP, PH_HALF, 24'h80_0000);
    send_tick(1'b0, 24'h00_0000);
    send_tick(1'b0, 24'h00_0000);
    // rectangle at both duty extremes
    set_voice(WF_RECTANGLE, 24'h02_0000, 24'h00_0000);
    send_tick(1'b1, 24'h00_0000);
    set_voice(WF_RECTANGLE, 24'h02_0000, 24'hFF_FFFF);
    send_tick(1'b1, 24'hFF_FFFF);
  endtask

  function automatic logic [23:0] pick_increment();
    case ($urandom_range(0, 9))
      0:       return 24'h00_0000;
      1:       return 24'($urandom_range(24'h40_0000, 24'h80_0000));
      2:       return 24'($urandom_range(24'h10_0000, 24'h3F_FFFF));
      default: return 24'($urandom_range(1, 24'h04_0000));
    endcase
  endfunction

  function automatic logic [23:0] pick_duty();
    case ($urandom_range(0, 5))
      0:       return 24'h00_0000;
      1:       return 24'hFF_FFFF;
      default: return 24'($urandom_range(0, 24'hFF_FFFF));
    endcase
  endfunction

  // sync phase aimed near the jumps and corners now and then
  function automatic logic [23:0] pick_phase();
    logic [23:0] near;
    near = 24'($urandom_range(0, 3) * PH_QUARTER);
    if ($urandom_range(0, 2) == 0) near = duty;
    if ($urandom_range(0, 1) == 0)
      return 24'(near + $urandom_range(0, 24'h00_0FFF) - 24'h00_0800);
    return 24'($urandom_range(0, 24'hFF_FFFF));
  endfunction

  task automatic test_random_voices();
    for (int ph = 0; ph < 12; ph++) begin
      set_voice(3'($urandom_range(0, 7)), pick_increment(), pick_duty());
      for (int n = 0; n < 45; n++) begin
        if ($urandom_range(0, 7) == 0) send_tick(1'b1, pick_phase());
        else send_tick(1'b0, 24'($urandom_range(0, 24'hFF_FFFF)));
      end
    end
  endtask

  // sink holds off for a long stretch while ticks keep coming
  task automatic test_backpressure();
    set_voice(WF_TRIANGLE, 24'h03_0000, 24'h40_0000);
    hold_request = 400;
    for (int n = 0; n < 20; n++)
      send_tick(1'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFF_FFFF)));
  endtask

  // both sides at full rate
  task automatic test_back_to_back();
    set_voice(WF_RECTANGLE, 24'h05_0000, 24'h30_0000);
    quiet_mode = 1'b1;
    for (int n = 0; n < 40; n++)
      send_tick($urandom_range(0, 3) == 0, 24'($urandom_range(0, 24'hFF_FFFF)));
    drain();
    quiet_mode = 1'b0;
  endtask

  initial begin
    cycle_count  = 0;
    mismatches   = 0;
    ticks_sent   = 0;
    samples_seen = 0;
    hold_request = 0;
    quiet_mode   = 1'b0;
    foreach (wave_hits[i]) wave_hits[i] = 0;
    // reset view of the block
    wave_sel  = WF_SINE;
    step_inc  = 24'd0;
    duty      = PH_HALF;
    acc_phase = 24'd0;
    for (int i = 0; i <= 256; i++) quarter_rom[i] = taylor_sine(PI_FIXED * i / 512);
    quarter_rom[257] = quarter_rom[256];

    rst_ni            <= 1'b0;
    cfg.valid         <= 1'b0;
    cfg.index         <= REG_WAVEFORM;
    cfg.data          <= '0;
    tick.valid        <= 1'b0;
    tick.sync_request <= 1'b0;
    tick.sync_phase   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a few samples at the reset settings first
    send_tick(1'b0, 24'd0);
    send_tick(1'b1, 24'h20_0000);
    test_directed();
    test_random_voices();
    test_backpressure();
    test_back_to_back();
    drain();

    $display("sent %0d ticks, checked %0d samples, %0d mismatches", ticks_sent,
             samples_seen, mismatches);
    $display("samples per waveform (sine includes high frequency): %p", wave_hits);
    if (mismatches == 0) begin
      $display("bandlimited_waveform_oscillator_top regression: pass");
    end else begin
      $display("bandlimited_waveform_oscillator_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
